FILE: sv/mba_pkg.sv
// ============================================================================
// mba_pkg
// Shared types and constants for the multichannel block averager.
// ============================================================================
package mba_pkg;

    localparam int CHANNELS    = 9;
    localparam int PORT_SHIFT  = 0;
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;

    localparam int CH_BITS     = 4;
    localparam int ID_BITS     = 11;
    localparam int AVG_BITS    = 12;
    localparam int SUM_BITS    = 28;
    localparam int STEP_BITS   = $clog2(SUM_BITS + 1);
    localparam int ADDR_BITS   = 2;
    localparam int DATA_BITS   = 32;

    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [ADDR_BITS-1:0] ADDR_BASE_FRAME_ID = 2'd0;

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } kind_t;

endpackage

FILE: sv/multichannel_block_averager.sv
// ============================================================================
// multichannel_block_averager
// Per-channel accumulate-and-dump averager with a shared restoring divider.
// ============================================================================
// Operation: a sample transaction updates its channel at the accept edge and
//   the block is ready again in the next cycle. A report tick runs the
//   divider one quotient bit per cycle (an empty channel skips it), then
//   loads the result and raises out_valid once the output register is free.
// Throughput: one sample per cycle while no tick is in progress; in_stall
//   holds new transactions until a tick's result has loaded.
// Reset: rst_n (async, active low) clears all sums, counts, the report
//   pointer, base_frame_id and the output valid.
module multichannel_block_averager
    import mba_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [CH_BITS-1:0]     channel,
    input  logic [SAMPLE_BITS-1:0] sample,

    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ID_BITS-1:0]     frame_id,
    output logic [CH_BITS-1:0]     reported_channel,
    output logic [AVG_BITS-1:0]    average,
    output logic                   empty_res,

    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg;

    // Per-channel accumulators
    logic [SUM_BITS-1:0]    sums_reg   [CHANNELS];
    logic [COUNT_BITS-1:0]  counts_reg [CHANNELS];
    logic [CH_BITS-1:0]     ptr_reg;
    logic [ID_BITS-1:0]     base_id_reg;

    // Divider working registers
    logic [SUM_BITS-1:0]    quo_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [COUNT_BITS-1:0]  divisor_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   empty_reg;

    // Output register
    logic                   out_valid_reg;
    logic [ID_BITS-1:0]     frame_id_reg;
    logic [CH_BITS-1:0]     rep_ch_reg;
    logic [AVG_BITS-1:0]    average_reg;
    logic                   empty_res_reg;

    logic                   in_take;
    logic                   cfg_write;
    logic                   ch_ok;
    logic [SUM_BITS:0]      sum_wide;
    logic [SUM_BITS-1:0]    sum_next;
    logic [COUNT_BITS:0]    trial_rem;
    logic [COUNT_BITS:0]    trial_diff;
    logic                   out_free;
    logic [CH_BITS-1:0]     ptr_next;
    logic [ID_BITS-1:0]     port_field;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_BASE_FRAME_ID);

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BASE_FRAME_ID)
                    ? {{(DATA_BITS-ID_BITS){1'b0}}, base_id_reg}
                    : '0;

    // Sample path: one saturating add on the addressed channel
    assign ch_ok    = (channel < CH_BITS'(CHANNELS));
    assign sum_wide = {1'b0, sums_reg[channel]} + (SUM_BITS+1)'(sample);
    assign sum_next = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

    // Restoring divider step: shift in the next dividend bit, try subtract
    assign trial_rem  = {rem_reg, quo_reg[SUM_BITS-1]};
    assign trial_diff = trial_rem - {1'b0, divisor_reg};

    // The result may load when the output register is free or being drained
    assign out_free = !out_valid_reg || !out_stall;

    assign ptr_next   = (ptr_reg == CH_BITS'(CHANNELS - 1)) ? '0 : ptr_reg + 1'b1;
    assign port_field = ID_BITS'({{(ID_BITS-CH_BITS){1'b0}}, ptr_reg} << PORT_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            base_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sums_reg[i]   <= '0;
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                base_id_reg <= pwdata[ID_BITS-1:0];
            end

            // Raise the valid when a result loads; drop it once the
            // downstream side takes the result
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        if (kind == KIND_TICK)
                        begin
                            // Latch the reported channel into the divider
                            quo_reg     <= sums_reg[ptr_reg];
                            divisor_reg <= counts_reg[ptr_reg];
                            rem_reg     <= '0;
                            step_reg    <= '0;
                            empty_reg   <= (counts_reg[ptr_reg] == '0);
                            state_reg   <= (counts_reg[ptr_reg] == '0) ? ST_DONE : ST_DIV;
                        end
                        else if (ch_ok && (counts_reg[channel] != COUNT_MAX))
                        begin
                            counts_reg[channel] <= counts_reg[channel] + 1'b1;
                            sums_reg[channel]   <= sum_next;
                        end
                    end
                end

                ST_DIV:
                begin
                    // One quotient bit per cycle, MSB first
                    if (!trial_diff[COUNT_BITS])
                    begin
                        rem_reg <= trial_diff[COUNT_BITS-1:0];
                        quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial_rem[COUNT_BITS-1:0];
                        quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_BITS'(SUM_BITS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    // Hold until the output register can take the result
                    if (out_free)
                    begin
                        frame_id_reg        <= base_id_reg | port_field;
                        rep_ch_reg          <= ptr_reg;
                        average_reg         <= empty_reg ? '0 : quo_reg[AVG_BITS-1:0];
                        empty_res_reg       <= empty_reg;
                        sums_reg[ptr_reg]   <= '0;
                        counts_reg[ptr_reg] <= '0;
                        ptr_reg             <= ptr_next;
                        state_reg           <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign frame_id         = frame_id_reg;
    assign reported_channel = rep_ch_reg;
    assign average          = average_reg;
    assign empty_res        = empty_res_reg;

endmodule
